[sv/potb_pkg.sv]
// ----------------------------------------------------------------------------
// Timer bank package
// Request kinds, timer states, controller states and the command and status
// groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package potb_pkg;

  localparam int MASK_W = 16;

  typedef enum logic [2:0] {
    KIND_TICK    = 3'd0,
    KIND_SETUP   = 3'd1,
    KIND_START   = 3'd2,
    KIND_STOP    = 3'd3,
    KIND_DESTROY = 3'd4,
    KIND_QUERY   = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_NONE      = 3'd0,
    ST_CREATED   = 3'd1,
    ST_STARTED   = 3'd2,
    ST_STOPPED   = 3'd3,
    ST_DESTROYED = 3'd4
  } tstate_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic capture;
    logic walk_clr;
    logic walk;
    logic exec;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_is_tick;
    logic walk_done;
  } sts_t;

endpackage

[sv/periodic_oneshot_timer_bank_top.sv]
// ----------------------------------------------------------------------------
// Periodic and one-shot timer bank
// A timer request is captured, executed in one step, then loaded for output.
// A tick walks the count memory one timer per cycle, then its result is loaded.
// No new request or tick is taken until the last result is loaded, as requests
// are sequenced one at a time and the count memory has a single read port.
// Reset clears all timer states and written flags at once; no sweep.
// ----------------------------------------------------------------------------
module periodic_oneshot_timer_bank_top #(
  parameter int TIMERS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  in_kind,
  input  logic [3:0]                  in_timer_index,
  input  logic [31:0]                 in_start_delay,
  input  logic [31:0]                 in_period,
  input  logic                        in_is_hard,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [potb_pkg::MASK_W-1:0] out_hard_fired,
  output logic [potb_pkg::MASK_W-1:0] out_soft_fired,
  output logic [2:0]                  out_timer_state,
  output logic [31:0]                 out_start_delay_out,
  output logic [31:0]                 out_period_out,
  output logic                        out_is_hard_out
);

  potb_pkg::cmd_t cmd;
  potb_pkg::sts_t sts;

  potb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  potb_dp #(
    .TIMERS (TIMERS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_kind             (in_kind),
    .in_timer_index      (in_timer_index),
    .in_start_delay      (in_start_delay),
    .in_period           (in_period),
    .in_is_hard          (in_is_hard),
    .out_hard_fired      (out_hard_fired),
    .out_soft_fired      (out_soft_fired),
    .out_timer_state     (out_timer_state),
    .out_start_delay_out (out_start_delay_out),
    .out_period_out      (out_period_out),
    .out_is_hard_out     (out_is_hard_out)
  );

endmodule

[sv/potb_ctrl.sv]
// ----------------------------------------------------------------------------
// Timer bank controller
// Sequences one request at a time: a single execute step for timer requests,
// a walk over all timers for a tick, then hand-off to the result register.
// ----------------------------------------------------------------------------
module potb_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  potb_pkg::sts_t  sts,
  output potb_pkg::cmd_t  cmd
);

  potb_pkg::fsm_t state_r, state_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_free;

  assign out_free  = !(out_valid_r && out_stall);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      potb_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.in_is_tick ? potb_pkg::S_WALK : potb_pkg::S_EXEC;
        end
      end
      potb_pkg::S_EXEC: begin
        state_nxt = potb_pkg::S_DONE;
      end
      potb_pkg::S_WALK: begin
        if (sts.walk_done) begin
          state_nxt = potb_pkg::S_DONE;
        end
      end
      potb_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = potb_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = potb_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      potb_pkg::S_IDLE: begin
        in_stall     = 1'b0;
        cmd.capture  = in_valid;
        cmd.walk_clr = in_valid && sts.in_is_tick;
      end
      potb_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
      end
      potb_pkg::S_WALK: begin
        cmd.walk = 1'b1;
      end
      potb_pkg::S_DONE: begin
        cmd.out_load = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= potb_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_tick_walks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && sts.in_is_tick) |=> state_r == potb_pkg::S_WALK)
    else $error("tick request did not start a walk");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && out_stall))
    else $error("result register overwritten while stalled");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.capture, cmd.walk, cmd.exec, cmd.out_load}))
    else $error("conflicting datapath commands");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("loaded result not presented");

endmodule

[sv/potb_dp.sv]
// ----------------------------------------------------------------------------
// Timer bank datapath
// Timer configuration and count memories, per-timer state and written flags,
// the request execute logic, the tick walk and the result register.
// ----------------------------------------------------------------------------
module potb_dp #(
  parameter int TIMERS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  potb_pkg::cmd_t              cmd,
  output potb_pkg::sts_t              sts,
  input  logic [2:0]                  in_kind,
  input  logic [3:0]                  in_timer_index,
  input  logic [31:0]                 in_start_delay,
  input  logic [31:0]                 in_period,
  input  logic                        in_is_hard,
  output logic [potb_pkg::MASK_W-1:0] out_hard_fired,
  output logic [potb_pkg::MASK_W-1:0] out_soft_fired,
  output logic [2:0]                  out_timer_state,
  output logic [31:0]                 out_start_delay_out,
  output logic [31:0]                 out_period_out,
  output logic                        out_is_hard_out
);

  localparam int IDX_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int CNT_W = $clog2(TIMERS + 1);

  logic [2:0]  kind_r;
  logic [3:0]  idx_r;
  logic [31:0] sd_r;
  logic [31:0] per_r;
  logic        hard_r;

  logic [64:0] cfg_mem [TIMERS];
  logic [31:0] rem_mem [TIMERS];
  logic [64:0] cfg_q_r;
  logic [31:0] rem_q_r;
  logic        rd_vld_r;

  logic [TIMERS-1:0]     vld_r;
  potb_pkg::tstate_t     st_r [TIMERS];
  logic [CNT_W-1:0]      cnt_r;

  logic [potb_pkg::MASK_W-1:0] res_hard_r, res_hard_nxt;
  logic [potb_pkg::MASK_W-1:0] res_soft_r, res_soft_nxt;
  logic [2:0]                  res_state_r, res_state_nxt;
  logic [31:0]                 res_sd_r, res_sd_nxt;
  logic [31:0]                 res_per_r, res_per_nxt;
  logic                        res_hd_r, res_hd_nxt;

  logic [potb_pkg::MASK_W-1:0] oh_r, os_r;
  logic [2:0]                  ost_r;
  logic [31:0]                 osd_r, oper_r;
  logic                        ohd_r;

  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  acc_addr;
  logic              idx_ok;
  potb_pkg::tstate_t cur_st;
  logic [31:0]       fd;
  logic [31:0]       rl;
  logic              hd;
  logic [31:0]       in_load;
  logic [31:0]       cur_load;
  logic [31:0]       dec;
  logic              fire;
  logic [potb_pkg::MASK_W-1:0] bit_oh;
  logic              cfg_we;
  logic              rem_we;
  logic [31:0]       rem_wd;
  logic              st_we;
  potb_pkg::tstate_t st_wd;
  logic              vld_set;
  logic              walk_proc;

  assign sts.in_is_tick = (in_kind == potb_pkg::KIND_TICK);
  assign sts.walk_done  = (cnt_r == CNT_W'(TIMERS));

  always_comb begin
    rd_addr   = cmd.walk ? IDX_W'(cnt_r) : IDX_W'(in_timer_index);
    acc_addr  = cmd.walk ? IDX_W'(cnt_r - CNT_W'(1)) : IDX_W'(idx_r);
    idx_ok    = ({3'b000, idx_r} < 7'(TIMERS));
    cur_st    = st_r[acc_addr];
    fd        = rd_vld_r ? cfg_q_r[31:0] : 32'd0;
    rl        = rd_vld_r ? cfg_q_r[63:32] : 32'd0;
    hd        = rd_vld_r && cfg_q_r[64];
    in_load   = (sd_r != 32'd0) ? sd_r : per_r;
    cur_load  = (fd != 32'd0) ? fd : rl;
    dec       = rem_q_r - 32'd1;
    fire      = (rem_q_r == 32'd0) || (rem_q_r == 32'd1);
    bit_oh    = potb_pkg::MASK_W'(1) << acc_addr;
    walk_proc = cmd.walk && (cnt_r != CNT_W'(0));
  end

  always_comb begin
    cfg_we        = 1'b0;
    rem_we        = 1'b0;
    rem_wd        = dec;
    st_we         = 1'b0;
    st_wd         = cur_st;
    vld_set       = 1'b0;
    res_hard_nxt  = res_hard_r;
    res_soft_nxt  = res_soft_r;
    res_state_nxt = res_state_r;
    res_sd_nxt    = res_sd_r;
    res_per_nxt   = res_per_r;
    res_hd_nxt    = res_hd_r;
    if (cmd.walk_clr) begin
      res_hard_nxt  = '0;
      res_soft_nxt  = '0;
      res_state_nxt = '0;
      res_sd_nxt    = '0;
      res_per_nxt   = '0;
      res_hd_nxt    = 1'b0;
    end else if (walk_proc) begin
      if (cur_st == potb_pkg::ST_STARTED) begin
        rem_we = 1'b1;
        if (fire) begin
          if (hd) begin
            res_hard_nxt = res_hard_r | bit_oh;
          end else begin
            res_soft_nxt = res_soft_r | bit_oh;
          end
          if (rl != 32'd0) begin
            rem_wd = rl;
          end else begin
            rem_wd = 32'd0;
            st_we  = 1'b1;
            st_wd  = potb_pkg::ST_STOPPED;
          end
        end
      end
    end else if (cmd.exec) begin
      res_hard_nxt  = '0;
      res_soft_nxt  = '0;
      res_state_nxt = '0;
      res_sd_nxt    = '0;
      res_per_nxt   = '0;
      res_hd_nxt    = 1'b0;
      if (idx_ok) begin
        res_state_nxt = cur_st;
        case (kind_r)
          potb_pkg::KIND_SETUP: begin
            cfg_we        = 1'b1;
            vld_set       = 1'b1;
            rem_we        = 1'b1;
            rem_wd        = in_load;
            st_we         = 1'b1;
            st_wd         = potb_pkg::ST_CREATED;
            res_state_nxt = potb_pkg::ST_CREATED;
          end
          potb_pkg::KIND_START: begin
            if (cur_st == potb_pkg::ST_CREATED || cur_st == potb_pkg::ST_STOPPED) begin
              rem_we        = 1'b1;
              rem_wd        = cur_load;
              st_we         = 1'b1;
              st_wd         = potb_pkg::ST_STARTED;
              res_state_nxt = potb_pkg::ST_STARTED;
            end
          end
          potb_pkg::KIND_STOP: begin
            if (cur_st == potb_pkg::ST_STARTED) begin
              st_we         = 1'b1;
              st_wd         = potb_pkg::ST_STOPPED;
              res_state_nxt = potb_pkg::ST_STOPPED;
            end
          end
          potb_pkg::KIND_DESTROY: begin
            st_we         = 1'b1;
            st_wd         = potb_pkg::ST_DESTROYED;
            res_state_nxt = potb_pkg::ST_DESTROYED;
          end
          potb_pkg::KIND_QUERY: begin
            res_sd_nxt  = fd;
            res_per_nxt = rl;
            res_hd_nxt  = hd;
          end
          default: begin
            res_state_nxt = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_we) begin
      cfg_mem[acc_addr] <= {hard_r, per_r, sd_r};
    end
    if (rem_we) begin
      rem_mem[acc_addr] <= rem_wd;
    end
    cfg_q_r  <= cfg_mem[rd_addr];
    rem_q_r  <= rem_mem[rd_addr];
    rd_vld_r <= vld_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      cnt_r <= '0;
      for (int i = 0; i < TIMERS; i++) begin
        st_r[i] <= potb_pkg::ST_NONE;
      end
    end else begin
      if (vld_set) begin
        vld_r[acc_addr] <= 1'b1;
      end
      if (st_we) begin
        st_r[acc_addr] <= st_wd;
      end
      if (cmd.walk_clr) begin
        cnt_r <= '0;
      end else if (cmd.walk && !sts.walk_done) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind;
      idx_r  <= in_timer_index;
      sd_r   <= in_start_delay;
      per_r  <= in_period;
      hard_r <= in_is_hard;
    end
    res_hard_r  <= res_hard_nxt;
    res_soft_r  <= res_soft_nxt;
    res_state_r <= res_state_nxt;
    res_sd_r    <= res_sd_nxt;
    res_per_r   <= res_per_nxt;
    res_hd_r    <= res_hd_nxt;
    if (cmd.out_load) begin
      oh_r   <= res_hard_r;
      os_r   <= res_soft_r;
      ost_r  <= res_state_r;
      osd_r  <= res_sd_r;
      oper_r <= res_per_r;
      ohd_r  <= res_hd_r;
    end
  end

  assign out_hard_fired      = oh_r;
  assign out_soft_fired      = os_r;
  assign out_timer_state     = ost_r;
  assign out_start_delay_out = osd_r;
  assign out_period_out      = oper_r;
  assign out_is_hard_out     = ohd_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TIMERS))
    else $error("walk counter beyond timer count");

  a_started_written: assert property (@(posedge clk) disable iff (!rst_n)
    ((cmd.exec && idx_ok) || walk_proc) && cur_st == potb_pkg::ST_STARTED |-> rd_vld_r)
    else $error("started timer has never been set up");

endmodule

[sim/periodic_oneshot_timer_bank_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer bank testbench
// Sends set up, start, stop, destroy, query and tick requests to the timer
// bank with random gaps on the input and random stalls on the output. A
// scoreboard keeps its own copy of every timer, works out the result of each
// accepted request and checks the results field by field, in order.
// ----------------------------------------------------------------------------
module periodic_oneshot_timer_bank_top_tb;

  localparam int TIMERS          = 16;
  localparam int RANDOM_REQUESTS = 1080;
  localparam int HOLD_CYCLES     = 400;
  localparam int WATCHDOG_LIMIT  = 3000;

  typedef struct packed {
    potb_pkg::kind_t kind;
    logic [3:0]      timer_index;
    logic [31:0]     start_delay;
    logic [31:0]     period;
    logic            is_hard;
  } timer_request_t;

  typedef struct packed {
    logic [15:0] hard_fired;
    logic [15:0] soft_fired;
    logic [2:0]  timer_state;
    logic [31:0] start_delay;
    logic [31:0] period;
    logic        is_hard;
  } timer_result_t;

  class timer_scoreboard;
    logic [31:0]       delay_cfg [TIMERS];
    logic [31:0]       period_cfg [TIMERS];
    logic [31:0]       countdown [TIMERS];
    potb_pkg::tstate_t status [TIMERS];
    bit                hard [TIMERS];
    timer_result_t     expected_results [$];
    int                errors;

    function new();
      for (int t = 0; t < TIMERS; t++) begin
        delay_cfg[t] = '0;
        period_cfg[t] = '0;
        countdown[t] = '0;
        status[t] = potb_pkg::ST_NONE;
        hard[t] = 1'b0;
      end
      errors = 0;
    endfunction

    function logic [31:0] load_count(int t);
      return (delay_cfg[t] != 0) ? delay_cfg[t] : period_cfg[t];
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_request(timer_request_t r);
      timer_result_t e;
      bit fire;
      int idx;
      e = '0;
      idx = int'(r.timer_index);
      if (r.kind == potb_pkg::KIND_TICK) begin
        for (int t = 0; t < TIMERS; t++) begin
          if (status[t] == potb_pkg::ST_STARTED) begin
            if (countdown[t] == 0) begin
              fire = 1'b1;
            end else begin
              countdown[t] = countdown[t] - 32'd1;
              fire = (countdown[t] == 0);
            end
            if (fire) begin
              if (hard[t]) e.hard_fired[t] = 1'b1;
              else e.soft_fired[t] = 1'b1;
              if (period_cfg[t] != 0) countdown[t] = period_cfg[t];
              else status[t] = potb_pkg::ST_STOPPED;
            end
          end
        end
      end else if (r.kind <= potb_pkg::KIND_QUERY) begin
        case (r.kind)
          potb_pkg::KIND_SETUP: begin
            delay_cfg[idx] = r.start_delay;
            period_cfg[idx] = r.period;
            hard[idx] = r.is_hard;
            countdown[idx] = load_count(idx);
            status[idx] = potb_pkg::ST_CREATED;
          end
          potb_pkg::KIND_START: begin
            if (status[idx] == potb_pkg::ST_CREATED ||
                status[idx] == potb_pkg::ST_STOPPED) begin
              countdown[idx] = load_count(idx);
              status[idx] = potb_pkg::ST_STARTED;
            end
          end
          potb_pkg::KIND_STOP: begin
            if (status[idx] == potb_pkg::ST_STARTED) status[idx] = potb_pkg::ST_STOPPED;
          end
          potb_pkg::KIND_DESTROY: begin
            status[idx] = potb_pkg::ST_DESTROYED;
          end
          default: begin
            e.start_delay = delay_cfg[idx];
            e.period = period_cfg[idx];
            e.is_hard = hard[idx];
          end
        endcase
        e.timer_state = status[idx];
      end
      expected_results.push_back(e);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(timer_result_t got);
      timer_result_t want;
      if (expected_results.size() == 0) begin
        $error("Result arrived with no request waiting for it.");
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("hard_fired", 32'(want.hard_fired), 32'(got.hard_fired));
      compare_field("soft_fired", 32'(want.soft_fired), 32'(got.soft_fired));
      compare_field("timer_state", 32'(want.timer_state), 32'(got.timer_state));
      compare_field("start_delay_out", want.start_delay, got.start_delay);
      compare_field("period_out", want.period, got.period);
      compare_field("is_hard_out", 32'(want.is_hard), 32'(got.is_hard));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_kind = potb_pkg::KIND_TICK;
  logic [3:0]  in_timer_index = '0;
  logic [31:0] in_start_delay = '0;
  logic [31:0] in_period = '0;
  logic        in_is_hard = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_hard_fired;
  logic [15:0] out_soft_fired;
  logic [2:0]  out_timer_state;
  logic [31:0] out_start_delay_out;
  logic [31:0] out_period_out;
  logic        out_is_hard_out;

  timer_scoreboard board = new();

  periodic_oneshot_timer_bank_top #(
    .TIMERS(TIMERS)
  ) i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_timer_index      (in_timer_index),
    .in_start_delay      (in_start_delay),
    .in_period           (in_period),
    .in_is_hard          (in_is_hard),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_hard_fired      (out_hard_fired),
    .out_soft_fired      (out_soft_fired),
    .out_timer_state     (out_timer_state),
    .out_start_delay_out (out_start_delay_out),
    .out_period_out      (out_period_out),
    .out_is_hard_out     (out_is_hard_out)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic timer_request_t make_request(potb_pkg::kind_t k, logic [3:0] idx,
                                                  logic [31:0] d, logic [31:0] p,
                                                  logic h);
    timer_request_t r;
    r.kind = k;
    r.timer_index = idx;
    r.start_delay = d;
    r.period = p;
    r.is_hard = h;
    return r;
  endfunction

  function automatic logic [31:0] pick_ticks();
    int roll = $urandom_range(99);
    if (roll < 55) return $urandom_range(4);
    if (roll < 85) return $urandom_range(24);
    if (roll < 92) return 32'hFFFF_FFFF - $urandom_range(2);
    return $urandom();
  endfunction

  function automatic timer_request_t random_request();
    int roll = $urandom_range(99);
    potb_pkg::kind_t k;
    if (roll < 32) k = potb_pkg::KIND_TICK;
    else if (roll < 52) k = potb_pkg::KIND_SETUP;
    else if (roll < 72) k = potb_pkg::KIND_START;
    else if (roll < 80) k = potb_pkg::KIND_STOP;
    else if (roll < 87) k = potb_pkg::KIND_DESTROY;
    else k = potb_pkg::KIND_QUERY;
    return make_request(k, 4'($urandom_range(15)), pick_ticks(), pick_ticks(),
                        1'($urandom_range(1)));
  endfunction

  task automatic send_request(input timer_request_t r, input bit may_idle);
    while (may_idle && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= r.kind;
    in_timer_index <= r.timer_index;
    in_start_delay <= r.start_delay;
    in_period <= r.period;
    in_is_hard <= r.is_hard;
    do @(posedge clk); while (in_stall);
    board.note_request(r);
  endtask

  task automatic direct(potb_pkg::kind_t k, logic [3:0] idx, logic [31:0] d,
                        logic [31:0] p, logic h);
    send_request(make_request(k, idx, d, p, h), 1'b1);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  initial begin : request_side
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    direct(potb_pkg::KIND_QUERY, 0, 0, 0, 0);
    direct(potb_pkg::KIND_START, 3, 0, 0, 0);
    direct(potb_pkg::KIND_STOP, 3, 0, 0, 0);
    direct(potb_pkg::KIND_DESTROY, 4, 0, 0, 0);
    direct(potb_pkg::KIND_SETUP, 0, 0, 0, 1);
    direct(potb_pkg::KIND_START, 0, 0, 0, 0);
    direct(potb_pkg::KIND_TICK, 0, 0, 0, 0);
    direct(potb_pkg::KIND_TICK, 0, 0, 0, 0);
    direct(potb_pkg::KIND_SETUP, 1, 2, 1, 0);
    direct(potb_pkg::KIND_START, 1, 0, 0, 0);
    direct(potb_pkg::KIND_TICK, 0, 0, 0, 0);
    direct(potb_pkg::KIND_TICK, 0, 0, 0, 0);
    direct(potb_pkg::KIND_TICK, 0, 0, 0, 0);
    direct(potb_pkg::KIND_SETUP, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
    direct(potb_pkg::KIND_QUERY, 15, 0, 0, 0);
    direct(potb_pkg::KIND_START, 15, 0, 0, 0);
    direct(potb_pkg::KIND_TICK, 0, 0, 0, 0);
    direct(potb_pkg::KIND_SETUP, 5, 1, 1, 0);
    direct(potb_pkg::KIND_START, 5, 0, 0, 0);
    direct(potb_pkg::KIND_SETUP, 5, 1, 1, 0);
    direct(potb_pkg::KIND_STOP, 1, 0, 0, 0);
    direct(potb_pkg::KIND_START, 1, 0, 0, 0);
    direct(potb_pkg::KIND_DESTROY, 1, 0, 0, 0);
    direct(potb_pkg::KIND_START, 1, 0, 0, 0);
    direct(potb_pkg::KIND_TICK, 0, 0, 0, 0);
    drain_results();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == 540) drain_results();
      send_request(random_request(), !(n >= 200 && n < 400));
    end

    drain_results();
    repeat (TIMERS + 8) @(posedge clk);
    if (board.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : result_side
    int seen;
    int hold_left;
    bit held;
    timer_result_t got;
    seen = 0;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.hard_fired = out_hard_fired;
        got.soft_fired = out_soft_fired;
        got.timer_state = out_timer_state;
        got.start_delay = out_start_delay_out;
        got.period = out_period_out;
        got.is_hard = out_is_hard_out;
        board.check_result(got);
        seen++;
      end
      if (!held && seen >= 400) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (seen >= 600 && seen < 800) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 21);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("*** FAILED ***");
    $finish;
  end

endmodule
